>>> design/homography_tracked_temporal_average_macros.svh
// Assertion helpers for the tracked temporal average block.
`ifndef HOMOGRAPHY_TRACKED_TEMPORAL_AVERAGE_MACROS_SVH
`define HOMOGRAPHY_TRACKED_TEMPORAL_AVERAGE_MACROS_SVH

// same-cycle implication
`define HTTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define HTTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> design/htta_pkg.sv
`default_nettype none
package htta_pkg;

	localparam int MAX_FRAMES_D = 4;
	localparam int MAX_WIDTH_D  = 256;
	localparam int MAX_HEIGHT_D = 256;

	localparam int LIM_W   = 9;              // image limits, at most 511
	localparam int FRAC    = 16;             // point fraction bits
	localparam int P_W     = LIM_W + FRAC;   // Q9.16 tracked point
	localparam int COEF_W  = 48;
	localparam int HALF_W  = COEF_W / 2;
	localparam int MUL_W   = 51;             // 25x26 signed product
	localparam int PP_W    = 49;             // low partial product
	localparam int FULL_W  = 76;
	localparam int ACC_W   = 59;             // numerator / depth sums
	localparam int MAG_W   = ACC_W - 1;
	localparam int NUM_W   = MAG_W + FRAC;
	localparam int DEN_W   = MAG_W + P_W - 1;
	localparam int Q_W     = P_W;
	localparam int CNT_W   = 5;
	localparam int CFG_W   = 9;

	typedef enum logic [1:0] {
		FN_PIX   = 2'd0,
		FN_COEF  = 2'd1,
		FN_QUERY = 2'd2,
		FN_RSVD  = 2'd3
	} func_e;

	localparam logic [1:0] REG_WINDOW = 2'd0;
	localparam logic [1:0] REG_WIDTH  = 2'd1;
	localparam logic [1:0] REG_HEIGHT = 2'd2;

	typedef enum logic [1:0] {
		DSEL_X,
		DSEL_Y,
		DSEL_AVG
	} dsel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SAMP,
		ST_SACC,
		ST_T_RD,
		ST_T_LO,
		ST_T_HI,
		ST_T_ADD,
		ST_LINK_END,
		ST_DIV_INIT,
		ST_DIV_STEP,
		ST_DIV_END,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic [1:0]               func;
		logic [1:0]               slot;
		logic [7:0]               pixel_x;
		logic [7:0]               pixel_y;
		logic [7:0]               pixel_value;
		logic [3:0]               coef_index;
		logic signed [COEF_W-1:0] coef_value;
	} in_t;

	typedef struct packed {
		logic [7:0] filtered_pixel;
		logic       depth_fault;
	} out_t;

endpackage
`default_nettype wire

>>> design/homography_tracked_temporal_average.sv
// Motion-compensated temporal average of one pixel, tracked through homographies.
// Input channel (in_valid/in_ready/in_data) carries one transaction per item:
//   pixel load and coefficient load give no result;
//   a query walks from the newest frame back through window_frames-1 links.
// Output channel (out_valid/out_ready/out_data) gives one transaction per query.
// A query samples each frame in turn and maps the point through each link on one
// shared 25x26 multiplier (two partial products per coefficient, six products per
// link) and one 25-step restoring divider, used for the x and y projective divides
// and the final average; a link with zero depth skips both projective divides.
// in_ready is high only while the sequencer is idle; one query is in flight.
// If the receiver stalls, the finished result waits in the sequencer until the
// output register frees up; a result already held stays stable meanwhile.
// Reset (arst_n low) clears control state and sets window 3, size 256x256.
// Frame and homography stores are not cleared; only written entries are valid.
// Configuration writes (cfg_we/cfg_index/cfg_data) take effect at once.
`default_nettype none
`include "homography_tracked_temporal_average_macros.svh"
module homography_tracked_temporal_average
	import htta_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_D,
	parameter int MAX_WIDTH  = MAX_WIDTH_D,
	parameter int MAX_HEIGHT = MAX_HEIGHT_D
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_t              in_data,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_t                  out_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);

	localparam int FA       = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int XA       = $clog2(MAX_WIDTH);
	localparam int YA       = $clog2(MAX_HEIGHT);
	localparam int FRAME_AW = FA + YA + XA;
	localparam int NLINK    = (MAX_FRAMES - 1) * 9;
	localparam int CA       = $clog2(NLINK);
	localparam int WW       = $clog2(MAX_FRAMES + 1);
	localparam int SUM_W    = 8 + $clog2(MAX_FRAMES);

	// ---------------------------------------------------------------- config
	logic [2:0]       win_q;
	logic [LIM_W-1:0] iw_q, ih_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= 3'd3;
			iw_q  <= LIM_W'(256);
			ih_q  <= LIM_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WINDOW: win_q <= cfg_data[2:0];
				REG_WIDTH:  iw_q  <= cfg_data;
				REG_HEIGHT: ih_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// saturated window and clamp limits, sampled when a query starts
	logic [WW-1:0]    w_sat;
	logic [LIM_W-1:0] xl_sat, yl_sat, sx, sy;

	always_comb begin
		if (win_q < 3'd2)                   w_sat = WW'(2);
		else if (int'(win_q) > MAX_FRAMES)  w_sat = WW'(MAX_FRAMES);
		else                                w_sat = WW'(win_q);
		if (iw_q == '0)                     xl_sat = '0;
		else if (int'(iw_q) > MAX_WIDTH)    xl_sat = LIM_W'(MAX_WIDTH - 1);
		else                                xl_sat = iw_q - 1'b1;
		if (ih_q == '0)                     yl_sat = '0;
		else if (int'(ih_q) > MAX_HEIGHT)   yl_sat = LIM_W'(MAX_HEIGHT - 1);
		else                                yl_sat = ih_q - 1'b1;
		sx = ({1'b0, in_data.pixel_x} > xl_sat) ? xl_sat : {1'b0, in_data.pixel_x};
		sy = ({1'b0, in_data.pixel_y} > yl_sat) ? yl_sat : {1'b0, in_data.pixel_y};
	end

	// ---------------------------------------------------------------- control
	state_t state_q, state_d;
	dsel_t  dsel_q;
	logic   in_acc;
	logic   out_load;
	logic   last_term;

	logic [FA-1:0]    z_q;
	logic [WW-1:0]    w_q;
	logic [LIM_W-1:0] xl_q, yl_q;
	logic [P_W-1:0]   qx_q, qy_q;
	logic [SUM_W-1:0] sum_q;
	logic             fault_q;
	logic [1:0]       row_q, col_q;
	logic signed [ACC_W-1:0] acc_q [0:2];
	logic [CNT_W-1:0] cnt_q;
	logic [Q_W-1:0]   quo_q;
	logic             dzero_q, dovf_q;
	logic [LIM_W-1:0] lim_q;
	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign last_term = (row_q == 2'd2) && (col_q == 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		unique case (state_q)
			ST_IDLE:
				if (in_acc && in_data.func == FN_QUERY) state_d = ST_SAMP;
			ST_SAMP: state_d = ST_SACC;
			ST_SACC: state_d = (z_q == '0) ? ST_DIV_INIT : ST_T_RD;
			ST_T_RD: state_d = ST_T_LO;
			ST_T_LO:
				if (col_q == 2'd2) state_d = last_term ? ST_LINK_END : ST_T_RD;
				else               state_d = ST_T_HI;
			ST_T_HI:  state_d = ST_T_ADD;
			ST_T_ADD: state_d = ST_T_RD;
			ST_LINK_END: state_d = (acc_q[2] == '0) ? ST_SAMP : ST_DIV_INIT;
			ST_DIV_INIT: state_d = ST_DIV_STEP;
			ST_DIV_STEP:
				if (cnt_q == CNT_W'(Q_W - 1)) state_d = ST_DIV_END;
			ST_DIV_END:
				unique case (dsel_q)
					DSEL_X:   state_d = ST_DIV_INIT;
					DSEL_Y:   state_d = ST_SAMP;
					default:  state_d = ST_OUT;
				endcase
			ST_OUT:
				if (!out_valid || out_ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------- stores
	logic [7:0]              fmem [0:(1 << FRAME_AW)-1];
	logic [7:0]              rd_q;
	logic                    fwe;
	logic [FRAME_AW-1:0]     fwaddr, fraddr;

	assign fwe = in_acc && (in_data.func == FN_PIX) && (int'(in_data.slot) < MAX_FRAMES)
		&& (int'(in_data.pixel_x) < MAX_WIDTH) && (int'(in_data.pixel_y) < MAX_HEIGHT);
	assign fwaddr = {FA'(in_data.slot), YA'(in_data.pixel_y), XA'(in_data.pixel_x)};
	assign fraddr = {z_q, YA'(qy_q[P_W-1:FRAC]), XA'(qx_q[P_W-1:FRAC])};

	always_ff @(posedge clk) begin
		if (fwe) fmem[fwaddr] <= in_data.pixel_value;
		rd_q <= fmem[fraddr];
	end

	logic signed [COEF_W-1:0] hmem [0:NLINK-1];
	logic signed [COEF_W-1:0] coef_q;
	logic                     cwe;
	logic [CA-1:0]            cwaddr, craddr;

	assign cwe = in_acc && (in_data.func == FN_COEF)
		&& (int'(in_data.slot) <= MAX_FRAMES - 2) && (int'(in_data.coef_index) < 9);
	assign cwaddr = CA'(int'(in_data.slot) * 9 + int'(in_data.coef_index));
	assign craddr = CA'(int'(z_q) * 9 + int'(row_q) * 3 + int'(col_q));

	always_ff @(posedge clk) begin
		if (cwe) hmem[cwaddr] <= in_data.coef_value;
		coef_q <= hmem[craddr];
	end

	// ---------------------------------------------------------------- multiplier
	// coefficient split in two halves; product of each half with the point
	logic signed [HALF_W:0]  opa;
	logic signed [P_W:0]     opb;
	logic signed [MUL_W-1:0] prod;
	logic signed [MUL_W-1:0] mul_q;
	logic [PP_W-1:0]         pp_q;
	logic signed [FULL_W-1:0] full;
	logic signed [ACC_W-1:0] term;

	always_comb begin
		if (state_q == ST_T_LO) opa = $signed({1'b0, coef_q[HALF_W-1:0]});
		else                    opa = $signed({coef_q[COEF_W-1], coef_q[COEF_W-1:HALF_W]});
		opb  = $signed({1'b0, (col_q == 2'd0) ? qx_q : qy_q});
		prod = opa * opb;
		full = (FULL_W'(mul_q) <<< HALF_W) + FULL_W'($signed({1'b0, pp_q}));
		// floor of c*p / 2^16
		term = ACC_W'(full >>> FRAC);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_T_LO || state_q == ST_T_HI) mul_q <= prod;
		if (state_q == ST_T_HI) pp_q <= mul_q[PP_W-1:0];
	end

	// ---------------------------------------------------------------- divider
	logic signed [ACC_W-1:0] dn, dd;
	logic [LIM_W-1:0]        dlim;
	logic [ACC_W-1:0]        an, ad;
	logic [MAG_W-1:0]        un, ud;
	logic                    ge;
	logic [P_W-1:0]          dres;

	always_comb begin
		unique case (dsel_q)
			DSEL_X: begin
				dn = acc_q[0]; dd = acc_q[2]; dlim = xl_q;
			end
			DSEL_Y: begin
				dn = acc_q[1]; dd = acc_q[2]; dlim = yl_q;
			end
			default: begin
				dn = ACC_W'(sum_q); dd = ACC_W'(w_q); dlim = '1;
			end
		endcase
		an = dn[ACC_W-1] ? ACC_W'(-dn) : dn;
		ad = dd[ACC_W-1] ? ACC_W'(-dd) : dd;
		un = an[MAG_W-1:0];
		ud = ad[MAG_W-1:0];
		ge = {{(DEN_W-NUM_W){1'b0}}, num_q} >= den_q;
		if (dzero_q)                                 dres = '0;
		else if (dovf_q || quo_q[Q_W-1:FRAC] >= lim_q) dres = {lim_q, {FRAC{1'b0}}};
		else                                         dres = quo_q;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_DIV_INIT: begin
				dzero_q <= (dn == '0) || (dn[ACC_W-1] != dd[ACC_W-1]);
				dovf_q  <= {{LIM_W{1'b0}}, un} >= {ud, {LIM_W{1'b0}}};
				lim_q   <= dlim;
				num_q   <= {un, {FRAC{1'b0}}};
				den_q   <= {ud, {(Q_W-1){1'b0}}};
				quo_q   <= '0;
				cnt_q   <= '0;
			end
			ST_DIV_STEP: begin
				if (ge) num_q <= num_q - den_q[NUM_W-1:0];
				den_q <= den_q >> 1;
				quo_q <= {quo_q[Q_W-2:0], ge};
				cnt_q <= cnt_q + 1'b1;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsel_q  <= DSEL_X;
			fault_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:     if (in_acc) fault_q <= 1'b0;
				ST_SACC:     if (z_q == '0) dsel_q <= DSEL_AVG;
				ST_LINK_END: begin
					if (acc_q[2] == '0) fault_q <= 1'b1;
					dsel_q <= DSEL_X;
				end
				ST_DIV_END:  if (dsel_q == DSEL_X) dsel_q <= DSEL_Y;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: if (in_acc) begin
				w_q   <= w_sat;
				z_q   <= FA'(w_sat - 1'b1);
				xl_q  <= xl_sat;
				yl_q  <= yl_sat;
				qx_q  <= {sx, {FRAC{1'b0}}};
				qy_q  <= {sy, {FRAC{1'b0}}};
				sum_q <= '0;
			end
			ST_SACC: begin
				sum_q <= sum_q + SUM_W'(rd_q);
				if (z_q != '0) begin
					z_q      <= z_q - 1'b1;
					row_q    <= '0;
					col_q    <= '0;
					acc_q[0] <= '0;
					acc_q[1] <= '0;
					acc_q[2] <= '0;
				end
			end
			ST_T_LO: if (col_q == 2'd2) begin
				// constant column
				acc_q[row_q] <= acc_q[row_q] + ACC_W'(coef_q);
				col_q        <= '0;
				row_q        <= row_q + 1'b1;
			end
			ST_T_ADD: begin
				acc_q[row_q] <= acc_q[row_q] + term;
				col_q        <= col_q + 1'b1;
			end
			ST_DIV_END: begin
				if (dsel_q == DSEL_X) qx_q <= dres;
				if (dsel_q == DSEL_Y) qy_q <= dres;
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------- output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)        out_valid <= 1'b0;
		else if (out_load)  out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data.filtered_pixel <= quo_q[FRAC+7:FRAC];
			out_data.depth_fault    <= fault_q;
		end
	end

	// ---------------------------------------------------------------- checks
	`HTTA_ASSERT_IMP(a_den_nonzero, clk, arst_n, state_q == ST_DIV_STEP, den_q != '0, "divide by zero")
	`HTTA_ASSERT_IMP(a_avg_range, clk, arst_n, state_q == ST_DIV_END && dsel_q == DSEL_AVG, !quo_q[Q_W-1], "average out of range")
	`HTTA_ASSERT_NXT(a_out_wait, clk, arst_n, state_q == ST_OUT && out_valid && !out_ready, state_q == ST_OUT, "pending result overwritten")
	`HTTA_ASSERT_IMP(a_link_window, clk, arst_n, state_q == ST_T_RD, (WW'(z_q) + 1'b1) < w_q, "link beyond window")

endmodule
`default_nettype wire

>>> sim/htta_scoreboard.sv
`default_nettype none
module htta_scoreboard
	import htta_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire in_t              in_data,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire out_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	output int                    errors,
	output int                    pending
);
	localparam int NFRM = MAX_FRAMES_D;
	localparam int NCELL = NFRM * MAX_WIDTH_D * MAX_HEIGHT_D;

	bit [7:0]         pix_mem [NCELL];
	bit signed [47:0] hmg_mem [(NFRM - 1) * 9];
	logic [2:0]       win_reg;
	logic [8:0]       wid_reg;
	logic [8:0]       hgt_reg;
	out_t             avg_q [$];

	initial errors = 0;
	assign pending = avg_q.size();

	// c * p / 2^16, floored, p is Q16.16
	function automatic logic signed [95:0] scale_pt(logic signed [47:0] c, logic [31:0] p);
		logic signed [95:0] cc, ip, fp;
		cc = c;
		ip = $signed({64'd0, p[31:16]});
		fp = $signed({80'd0, p[15:0]});
		return cc * ip + ((cc * fp) >>> 16);
	endfunction

	// projective divide to Q16.16, clamped to [0, lim]
	function automatic logic [31:0] proj_div(logic signed [95:0] n, logic signed [95:0] d,
			logic [31:0] lim);
		logic [95:0] un, ud, ip, r;
		logic [31:0] fr;
		fr = 0;
		if (n == 0 || ((n < 0) != (d < 0)))
			return 0;
		un = n < 0 ? -n : n;
		ud = d < 0 ? -d : d;
		ip = un / ud;
		if (ip >= lim)
			return lim << 16;
		r = un % ud;
		for (int i = 0; i < 16; i++) begin
			r = r << 1;
			fr = fr << 1;
			if (r >= ud) begin
				r = r - ud;
				fr[0] = 1'b1;
			end
		end
		return (ip[31:0] << 16) | fr;
	endfunction

	function automatic int pix_at(int s, logic [31:0] x, logic [31:0] y);
		return pix_mem[(s * MAX_HEIGHT_D + int'(y >> 16)) * MAX_WIDTH_D + int'(x >> 16)];
	endfunction

	function automatic out_t track_average(logic [7:0] px, logic [7:0] py);
		int w, xl, yl, acc;
		logic [31:0] qx, qy;
		logic signed [95:0] dd, nx, ny;
		logic flt;
		out_t r;
		w = win_reg < 2 ? 2 : (win_reg > NFRM ? NFRM : win_reg);
		xl = (wid_reg < 1 ? 1 : (wid_reg > MAX_WIDTH_D ? MAX_WIDTH_D : wid_reg)) - 1;
		yl = (hgt_reg < 1 ? 1 : (hgt_reg > MAX_HEIGHT_D ? MAX_HEIGHT_D : hgt_reg)) - 1;
		qx = (px > xl ? xl : px) << 16;
		qy = (py > yl ? yl : py) << 16;
		acc = pix_at(w - 1, qx, qy);
		flt = 0;
		for (int z = w - 2; z >= 0; z--) begin
			dd = scale_pt(hmg_mem[z*9+6], qx) + scale_pt(hmg_mem[z*9+7], qy) + hmg_mem[z*9+8];
			if (dd == 0) begin
				flt = 1;
			end else begin
				nx = scale_pt(hmg_mem[z*9+0], qx) + scale_pt(hmg_mem[z*9+1], qy)
					+ hmg_mem[z*9+2];
				ny = scale_pt(hmg_mem[z*9+3], qx) + scale_pt(hmg_mem[z*9+4], qy)
					+ hmg_mem[z*9+5];
				qx = proj_div(nx, dd, xl);
				qy = proj_div(ny, dd, yl);
			end
			acc += pix_at(z, qx, qy);
		end
		r.filtered_pixel = 8'(acc / w);
		r.depth_fault = flt;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t got, want;
		if (!arst_n) begin
			win_reg <= 3'd3;
			wid_reg <= 9'd256;
			hgt_reg <= 9'd256;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
				REG_WINDOW: win_reg <= cfg_data[2:0];
				REG_WIDTH:  wid_reg <= cfg_data;
				REG_HEIGHT: hgt_reg <= cfg_data;
				default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (in_data.func)
				FN_PIX:
					pix_mem[(int'(in_data.slot) * MAX_HEIGHT_D + in_data.pixel_y) * MAX_WIDTH_D
						+ in_data.pixel_x] = in_data.pixel_value;
				FN_COEF:
					if (in_data.slot <= NFRM - 2 && in_data.coef_index < 9)
						hmg_mem[in_data.slot * 9 + in_data.coef_index] = in_data.coef_value;
				FN_QUERY:
					avg_q = {avg_q, track_average(in_data.pixel_x, in_data.pixel_y)};
				default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				got = out_data;
				if (avg_q.size() == 0) begin
					$error("result transaction with nothing expected");
					errors++;
				end else begin
					want = avg_q.pop_front();
					if (got.filtered_pixel !== want.filtered_pixel) begin
						$error("filtered_pixel expected %0d got %0d",
							want.filtered_pixel, got.filtered_pixel);
						errors++;
					end
					if (got.depth_fault !== want.depth_fault) begin
						$error("depth_fault expected %0d got %0d",
							want.depth_fault, got.depth_fault);
						errors++;
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
	import htta_pkg::*;

	localparam longint ONE = 64'sd1 << 32;     // 1.0 in Q15.32
	localparam int     SETTLE = 400;           // > worst query latency
	localparam int     LIMIT = 3_000_000;
	localparam int     IMG = 8;                // image corner that queries stay in

	logic             clk = 0;
	logic             arst_n = 0;
	logic             in_valid = 0;
	logic             in_ready;
	in_t              in_data = '0;
	logic             out_valid;
	logic             out_ready = 0;
	out_t             out_data;
	logic             cfg_we = 0;
	logic [1:0]       cfg_index = REG_WINDOW;
	logic [CFG_W-1:0] cfg_data = '0;

	int errors, pending;
	int tx_idle = 0;        // percent of cycles the sender sits out
	int rx_idle = 0;        // percent of cycles the receiver stalls
	int hold_reqs = 0;      // bumped by stimulus to request a long output stall
	int hold_seen = 0;
	int hold_left = 0;
	int cycles = 0;

	always #5 clk = ~clk;

	homography_tracked_temporal_average dut (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data
	);

	htta_scoreboard chk (
		.clk, .arst_n, .in_valid, .in_ready, .in_data,
		.out_valid, .out_ready, .out_data, .cfg_we, .cfg_index, .cfg_data,
		.errors, .pending
	);

	// Watchdog: any hang ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off counted here when asked for.
	always @(posedge clk) begin
		if (hold_seen != hold_reqs) begin
			hold_seen <= hold_seen + 1;
			hold_left <= 600;
			out_ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ready <= 0;
		end else begin
			out_ready <= $urandom_range(99) >= rx_idle;
		end
	end

	// One input transaction. Called at a rising edge; returns at the edge that accepted it.
	// A gap lowers valid in one step and raises it in a later one, never both at once.
	task automatic send(in_t item);
		while ($urandom_range(99) < tx_idle) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		in_data <= item;
		// ready is sampled mid-cycle, away from the edge
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
	endtask

	task automatic put_pixel(int s, int x, int y, int v);
		in_t t;
		t = in_t'(80'({$urandom, $urandom, $urandom}));
		t.func = FN_PIX;
		t.slot = 2'(s);
		t.pixel_x = 8'(x);
		t.pixel_y = 8'(y);
		t.pixel_value = 8'(v);
		send(t);
	endtask

	task automatic put_coef(int s, int k, longint c);
		in_t t;
		t = in_t'(80'({$urandom, $urandom, $urandom}));
		t.func = FN_COEF;
		t.slot = 2'(s);
		t.coef_index = 4'(k);
		t.coef_value = c[47:0];
		send(t);
	endtask

	task automatic ask(int x, int y);
		in_t t;
		t = in_t'(80'({$urandom, $urandom, $urandom}));
		t.func = FN_QUERY;
		t.pixel_x = 8'(x);
		t.pixel_y = 8'(y);
		send(t);
	endtask

	// Coefficient of a plausible camera-motion homography: near identity,
	// a shift of up to 20 pixels, mild perspective. Rarely a zero depth row.
	function automatic longint motion_coef(int k, bit flat);
		longint f;
		f = longint'($urandom_range(1 << 28)) - (1 << 27);
		if (flat && k >= 6)
			return 0;
		case (k)
		0, 4:    return ONE + f;
		1, 3:    return f;
		2, 5:    return (longint'($urandom_range(40)) - 20) * ONE + f;
		6, 7:    return f >>> 6;
		default: return ONE + (f >>> 4);
		endcase
	endfunction

	task automatic load_motion(int s);
		bit flat;
		flat = $urandom_range(29) == 0;
		for (int k = 0; k < 9; k++)
			put_coef(s, k, motion_coef(k, flat));
	endtask

	task automatic load_matrix(int s, longint m[9]);
		for (int k = 0; k < 9; k++)
			put_coef(s, k, m[k]);
	endtask

	// Input goes quiet for the write, so no transaction shares its edge.
	task automatic set_reg(logic [1:0] idx, int val);
		in_valid <= 0;
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
		cfg_we <= 0;
	endtask

	// Sender goes quiet until every expected result is back, then the block settles.
	task automatic drain();
		in_valid <= 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Random traffic: mostly well-formed, with queries dominating.
	task automatic traffic(int n);
		int r;
		in_t t;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			if (r < 45) begin
				ask($urandom_range(2 * IMG), $urandom_range(2 * IMG));
			end else if (r < 75) begin
				put_pixel($urandom_range(3), $urandom_range(IMG - 1), $urandom_range(IMG - 1),
					$urandom_range(255));
			end else if (r < 85) begin
				put_coef($urandom_range(2), $urandom_range(8), motion_coef($urandom_range(8), 0));
			end else if (r < 91) begin
				load_motion($urandom_range(2));
			end else begin
				// noise: any slot, any index, raw coefficient, or the unused code
				t = in_t'(80'({$urandom, $urandom, $urandom}));
				t.func = $urandom_range(1) ? FN_COEF : FN_RSVD;
				send(t);
			end
		end
	endtask

	initial begin
		longint m[9];

		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Queries stay in an IMG x IMG corner; fill it in every frame slot.
		set_reg(REG_WIDTH, IMG);
		set_reg(REG_HEIGHT, IMG);
		for (int s = 0; s < MAX_FRAMES_D; s++)
			for (int y = 0; y < IMG; y++)
				for (int x = 0; x < IMG; x++)
					put_pixel(s, x, y, $urandom_range(255));

		// Directed: identity links, then corners at window 3.
		m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE};
		for (int s = 0; s < 3; s++)
			load_matrix(s, m);
		put_pixel(2, IMG - 1, IMG - 1, 255);
		put_pixel(1, IMG - 1, IMG - 1, 255);
		put_pixel(0, IMG - 1, IMG - 1, 255);
		ask(0, 0);
		ask(255, 255);

		// Coefficient loads that must be dropped: link slot past the last, index past 8.
		put_coef(3, 0, -ONE);
		put_coef(0, 9, -ONE);
		put_coef(1, 15, 0);
		ask(255, 255);

		// Unused code gives no result.
		begin
			in_t t;
			t = '1;
			t.func = FN_RSVD;
			send(t);
		end

		// Shift far left: negative quotients clamp to column 0.
		m = '{ONE, 0, -300 * ONE, 0, ONE, 0, 0, 0, ONE};
		load_matrix(1, m);
		ask(5, 3);
		// Shift far right/down: quotient past the image clamps to the edge.
		m = '{ONE, 0, 600 * ONE, 0, ONE, 600 * ONE, 0, 0, ONE};
		load_matrix(1, m);
		ask(2, 2);
		// Zero depth row: point held, fault raised.
		m = '{ONE, 0, 0, 0, ONE, 0, 0, 0, 0};
		load_matrix(0, m);
		ask(4, 6);
		// Extreme coefficients in links 1 and 2.
		m = '{64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF,
			-64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000,
			-64'sh8000_0000_0000, 64'sh7FFF_FFFF_FFFF, -64'sh8000_0000_0000};
		load_matrix(2, m);
		load_matrix(1, m);
		drain();

		// Window extremes plus out-of-range values that saturate.
		set_reg(REG_WINDOW, 4);
		ask(255, 0);
		drain();
		// Window 2 uses link 0 only, which has zero depth: the point stays on row 200.
		put_pixel(1, 0, 200, $urandom_range(255));
		put_pixel(0, 0, 200, $urandom_range(255));
		set_reg(REG_WINDOW, 0);
		set_reg(REG_WIDTH, 1);
		set_reg(REG_HEIGHT, 511);
		ask(200, 200);
		drain();
		set_reg(REG_WINDOW, 7);
		set_reg(REG_WIDTH, 0);
		set_reg(REG_HEIGHT, 0);
		ask(255, 255);
		drain();
		for (int s = 0; s < 3; s++)
			load_motion(s);

		// Phase 1: sender mostly busy, receiver stalls half the time.
		set_reg(REG_WINDOW, 3);
		set_reg(REG_WIDTH, IMG);
		set_reg(REG_HEIGHT, IMG);
		tx_idle = 13;
		rx_idle = 51;
		traffic(35);
		drain();

		// Phase 2: the other way round, random size, longest window.
		set_reg(REG_WINDOW, 4);
		set_reg(REG_WIDTH, $urandom_range(1, IMG));
		set_reg(REG_HEIGHT, $urandom_range(1, IMG));
		tx_idle = 51;
		rx_idle = 13;
		traffic(35);
		drain();

		// Phase 3: no idling, shortest window, random size.
		set_reg(REG_WINDOW, 2);
		set_reg(REG_WIDTH, $urandom_range(1, IMG));
		set_reg(REG_HEIGHT, $urandom_range(1, IMG));
		tx_idle = 0;
		rx_idle = 0;
		traffic(35);
		drain();

		// Phase 4: long output stall while queries keep coming, so the input backs up.
		set_reg(REG_WINDOW, 4);
		set_reg(REG_WIDTH, IMG);
		set_reg(REG_HEIGHT, IMG);
		hold_reqs++;
		for (int i = 0; i < 12; i++)
			ask($urandom_range(2 * IMG), $urandom_range(2 * IMG));
		traffic(15);
		drain();

		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
`default_nettype wire
